@@ design/eaf_pkg.sv @@
// Shared types, constants and fixed-point helpers for the elliptical arc flattener.
// No dependencies; every other design file imports this package.
package eaf_pkg;

    localparam int CW          = 40;
    localparam int STEP_W      = 7;
    localparam int MAX_SEG_DEF = 64;
    localparam int CORDIC_N    = 30;

    localparam logic signed [CW-1:0] GAIN_Q30 = 40'sd652032874;
    localparam logic [63:0] PI_Q24   = 64'd52707179;
    localparam logic [63:0] ONE_Q60  = 64'd1 << 60;
    localparam logic [63:0] RAD_MAX  = 64'd1 << 31;
    localparam logic [63:0] AMT_SAT  = 64'd1 << 37;
    localparam logic [63:0] CEIL_ADD = (64'd1 << 56) - 64'd1;
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;

    typedef struct packed {
        logic               go;
        logic [63:0]        a;
        logic [63:0]        b;
    } t_mul_req;

    typedef struct packed {
        logic               go;
        logic signed [63:0] num;
        logic signed [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic               go;
        logic [63:0]        v;
    } t_sqrt_req;

    typedef struct packed {
        logic                 go;
        logic                 vec;
        logic [31:0]          ang;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } t_cor_req;

    typedef struct packed {
        logic signed [31:0]   xe;
        logic signed [31:0]   ye;
        logic signed [32:0]   sumx;
        logic signed [32:0]   sumy;
        logic signed [CW-1:0] c;
        logic signed [CW-1:0] s;
        logic signed [33:0]   cx1;
        logic signed [33:0]   cy1;
        logic [31:0]          rxs;
        logic [31:0]          rys;
        logic [31:0]          th1;
        logic                 sw;
        logic [31:0]          qstep;
        logic [STEP_W-1:0]    rstep;
        logic [STEP_W-1:0]    steps;
    } t_job;

    function automatic logic [31:0] atan_val(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                   input logic [5:0] n);
        logic signed [63:0] h;
        logic signed [63:0] m;
        h = 64'sd1 <<< (n - 6'd1);
        m = -v;
        if (v >= 0) begin
            return (v + h) >>> n;
        end
        return -((m + h) >>> n);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] sx64(input logic signed [CW-1:0] v);
        return {{(64-CW){v[CW-1]}}, v};
    endfunction

endpackage

@@ design/eaf_mul.sv @@
// Multi-cycle 64-bit multiplier giving the low 64 bits of the product.
// Takes one 16-bit digit of the second operand per cycle; uses eaf_pkg.
module eaf_mul import eaf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_mul_req    i_req,
    output logic        o_done,
    output logic [63:0] o_p
);
    logic [63:0] r_a, r_b, r_acc;
    logic [1:0]  r_cnt;
    logic        r_run, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_a   <= i_req.a;
                r_b   <= i_req.b;
                r_acc <= 64'd0;
                r_cnt <= 2'd0;
                r_run <= 1'b1;
            end else if (r_run) begin
                r_acc <= r_acc + r_a * {48'd0, r_b[15:0]};
                r_a   <= r_a << 16;
                r_b   <= r_b >> 16;
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;
endmodule

@@ design/eaf_div.sv @@
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
// Uses eaf_pkg for its request type.
module eaf_div import eaf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_div_req           i_req,
    output logic               o_done,
    output logic signed [63:0] o_q,
    output logic signed [63:0] o_r
);
    logic [63:0] r_den, r_quo;
    logic [64:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_run, r_done, r_sq, r_sr;
    logic [64:0] n_sh;

    always_comb begin
        n_sh = {r_rem[63:0], r_quo[63]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_den <= i_req.den[63] ? 64'(-i_req.den) : 64'(i_req.den);
                r_quo <= i_req.num[63] ? 64'(-i_req.num) : 64'(i_req.num);
                r_rem <= 65'd0;
                r_sq  <= i_req.num[63] ^ i_req.den[63];
                r_sr  <= i_req.num[63];
                r_cnt <= 6'd0;
                r_run <= 1'b1;
            end else if (r_run) begin
                if (n_sh >= {1'b0, r_den}) begin
                    r_rem <= n_sh - {1'b0, r_den};
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= n_sh;
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_sq ? -$signed(r_quo) : $signed(r_quo);
    assign o_r    = r_sr ? -$signed(r_rem[63:0]) : $signed(r_rem[63:0]);
endmodule

@@ design/eaf_isqrt.sv @@
// Integer square root of a 64-bit value, two radicand bits per cycle.
// Uses eaf_pkg for its request type.
module eaf_isqrt import eaf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_sqrt_req   i_req,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic [63:0] r_v, r_r, r_bit;
    logic [4:0]  r_cnt;
    logic        r_run, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_v   <= i_req.v;
                r_r   <= 64'd0;
                r_bit <= 64'd1 << 62;
                r_cnt <= 5'd0;
                r_run <= 1'b1;
            end else if (r_run) begin
                if (r_v >= r_r + r_bit) begin
                    r_v <= r_v - (r_r + r_bit);
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[31:0];
endmodule

@@ design/eaf_cordic.sv @@
// Iterative CORDIC, one micro-rotation per cycle: sine/cosine or vector angle.
// Uses the arctangent table and gain constant of eaf_pkg.
module eaf_cordic import eaf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cor_req             i_req,
    output logic                 o_done,
    output logic signed [CW-1:0] o_x,
    output logic signed [CW-1:0] o_y,
    output logic [31:0]          o_z
);
    logic signed [CW-1:0] r_x, r_y;
    logic signed [33:0]   r_z;
    logic [4:0]           r_i;
    logic                 r_run, r_done, r_vec, r_neg;
    logic signed [33:0]   n_za;
    logic signed [CW-1:0] n_xs, n_ys;
    logic signed [33:0]   n_at;
    logic                 n_ccw;

    always_comb begin
        n_za  = 34'(signed'(i_req.ang));
        n_xs  = r_x >>> r_i;
        n_ys  = r_y >>> r_i;
        n_at  = $signed({2'b00, atan_val(r_i)});
        n_ccw = r_vec ? !(r_y > 0) : (r_z >= 0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_i    <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_vec <= i_req.vec;
                r_i   <= 5'd0;
                r_run <= 1'b1;
                if (i_req.vec) begin
                    r_neg <= 1'b0;
                    if (i_req.x < 0) begin
                        r_x <= -i_req.x;
                        r_y <= -i_req.y;
                        r_z <= 34'sh0_8000_0000;
                    end else begin
                        r_x <= i_req.x;
                        r_y <= i_req.y;
                        r_z <= 34'sd0;
                    end
                end else begin
                    r_x <= GAIN_Q30;
                    r_y <= '0;
                    if (n_za > 34'sd1073741824) begin
                        r_z   <= n_za - 34'sd2147483648;
                        r_neg <= 1'b1;
                    end else if (n_za < -34'sd1073741824) begin
                        r_z   <= n_za + 34'sd2147483648;
                        r_neg <= 1'b1;
                    end else begin
                        r_z   <= n_za;
                        r_neg <= 1'b0;
                    end
                end
            end else if (r_run) begin
                if (n_ccw) begin
                    r_x <= r_x - n_ys;
                    r_y <= r_y + n_xs;
                    r_z <= r_z - n_at;
                end else begin
                    r_x <= r_x + n_ys;
                    r_y <= r_y - n_xs;
                    r_z <= r_z + n_at;
                end
                r_i <= r_i + 5'd1;
                if (r_i == 5'(CORDIC_N - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_neg ? -r_x : r_x;
    assign o_y    = r_neg ? -r_y : r_y;
    assign o_z    = r_z[31:0];
endmodule

@@ design/eaf_front.sv @@
// Setup sequencer: accepts an arc word, finds centre, angles and chord count.
// Uses eaf_pkg and the eaf_mul, eaf_div, eaf_isqrt and eaf_cordic units.
module eaf_front import eaf_pkg::*; #(
    parameter int MAX_SEGMENTS = MAX_SEG_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [31:0] i_radius_x,
    input  logic signed [31:0] i_radius_y,
    input  logic [15:0]        i_rotation,
    input  logic               i_large_arc,
    input  logic               i_sweep,
    input  logic signed [31:0] i_end_x,
    input  logic signed [31:0] i_end_y,
    input  logic               i_full,
    output logic               o_push,
    output t_job               o_job
);
    localparam logic [4:0] F_IDLE = 5'd0,  F_PHI = 5'd1,  F_M1 = 5'd2,  F_M2 = 5'd3;
    localparam logic [4:0] F_M3 = 5'd4,    F_M4 = 5'd5,   F_DA = 5'd6,  F_DB = 5'd7;
    localparam logic [4:0] F_NORM = 5'd8,  F_SA = 5'd9,   F_SB = 5'd10, F_SQ = 5'd11;
    localparam logic [4:0] F_RX = 5'd12,   F_RY = 5'd13,  F_ST = 5'd14, F_TB = 5'd15;
    localparam logic [4:0] F_DX = 5'd16,   F_TA = 5'd17,  F_DY = 5'd18, F_V1 = 5'd19;
    localparam logic [4:0] F_V2 = 5'd20,   F_CX = 5'd21,  F_CY = 5'd22, F_AMT = 5'd23;
    localparam logic [4:0] F_PI = 5'd24,   F_QR = 5'd25,  F_PUSH = 5'd26;

    logic [4:0]           r_state;
    logic                 r_run, r_la, r_sw, r_scaled;
    logic signed [31:0]   r_x0, r_y0, r_xe, r_ye;
    logic signed [63:0]   r_rx, r_ry;
    logic [15:0]          r_phi;
    logic signed [CW-1:0] r_c, r_s;
    logic signed [63:0]   r_p, r_x1, r_y1, r_a, r_b, r_cux, r_cuy;
    logic [63:0]          r_ma, r_mb, r_lsq, r_amt;
    logic [31:0]          r_n, r_t, r_th1, r_ext, r_rxs, r_rys, r_qstep;
    logic [5:0]           r_sh;
    logic signed [33:0]   r_cx1, r_cy1;
    logic [STEP_W-1:0]    r_steps, r_rstep;

    t_mul_req  mreq;
    t_div_req  dreq;
    t_sqrt_req sreq;
    t_cor_req  creq;
    logic               mul_done, div_done, sqrt_done, cor_done, unit_done;
    logic [63:0]        mul_p;
    logic signed [63:0] div_q, div_r;
    logic [31:0]        sqrt_r;
    logic signed [CW-1:0] cor_x, cor_y;
    logic [31:0]        cor_z;

    logic signed [63:0] n_dx, n_dy, n_rxa, n_rya;
    logic [63:0]        n_lsq, n_prod, n_maxs;
    logic [31:0]        n_d;

    eaf_mul    u_mul  (.i_clk, .i_rst_n, .i_req(mreq), .o_done(mul_done), .o_p(mul_p));
    eaf_div    u_div  (.i_clk, .i_rst_n, .i_req(dreq), .o_done(div_done),
                       .o_q(div_q), .o_r(div_r));
    eaf_isqrt  u_sqrt (.i_clk, .i_rst_n, .i_req(sreq), .o_done(sqrt_done), .o_root(sqrt_r));
    eaf_cordic u_cor  (.i_clk, .i_rst_n, .i_req(creq), .o_done(cor_done),
                       .o_x(cor_x), .o_y(cor_y), .o_z(cor_z));

    function automatic logic [31:0] scale_rad(input logic [63:0] v, input logic [5:0] sh);
        logic [63:0] w;
        logic [5:0]  k;
        w = v;
        k = 6'd0;
        if (sh < 6'd30) begin
            k = 6'd30 - sh;
            w = (v + (64'd1 << (k - 6'd1))) >> k;
        end else if (sh > 6'd30) begin
            k = sh - 6'd30;
            w = (v > (RAD_MAX >> k)) ? RAD_MAX : (v << k);
        end
        if (w > RAD_MAX) begin
            w = RAD_MAX;
        end
        return w[31:0];
    endfunction

    always_comb begin
        n_dx   = 64'(r_x0) - 64'(r_xe);
        n_dy   = 64'(r_y0) - 64'(r_ye);
        n_rxa  = i_radius_x[31] ? -64'(i_radius_x) : 64'(i_radius_x);
        n_rya  = i_radius_y[31] ? -64'(i_radius_y) : 64'(i_radius_y);
        n_lsq  = r_p + mul_p;
        n_prod = (mul_p + CEIL_ADD) >> 56;
        n_maxs = 64'(MAX_SEGMENTS);
        n_d    = cor_z - r_th1;
        unit_done = mul_done | div_done | sqrt_done | cor_done;
    end

    always_comb begin
        mreq = '0;
        dreq = '0;
        sreq = '0;
        creq = '0;
        case (r_state)
            F_PHI: begin
                creq.go  = !r_run;
                creq.ang = {r_phi, 16'h0000};
            end
            F_M1: begin
                mreq.go = !r_run; mreq.a = sx64(r_c); mreq.b = n_dx;
            end
            F_M2: begin
                mreq.go = !r_run; mreq.a = sx64(r_s); mreq.b = n_dy;
            end
            F_M3: begin
                mreq.go = !r_run; mreq.a = sx64(r_c); mreq.b = n_dy;
            end
            F_M4: begin
                mreq.go = !r_run; mreq.a = sx64(r_s); mreq.b = n_dx;
            end
            F_DA: begin
                dreq.go = !r_run; dreq.num = r_x1 <<< 30; dreq.den = r_rx;
            end
            F_DB: begin
                dreq.go = !r_run; dreq.num = r_y1 <<< 30; dreq.den = r_ry;
            end
            F_SA: begin
                mreq.go = !r_run; mreq.a = r_a; mreq.b = r_a;
            end
            F_SB: begin
                mreq.go = !r_run; mreq.a = r_b; mreq.b = r_b;
            end
            F_SQ: begin
                sreq.go = !r_run; sreq.v = r_lsq;
            end
            F_RX: begin
                mreq.go = !r_run; mreq.a = r_rx; mreq.b = {32'd0, r_n};
            end
            F_RY: begin
                mreq.go = !r_run; mreq.a = r_ry; mreq.b = {32'd0, r_n};
            end
            F_ST: begin
                sreq.go = !r_run; sreq.v = ONE_Q60 - r_lsq;
            end
            F_TB: begin
                mreq.go = !r_run; mreq.a = {32'd0, r_t}; mreq.b = r_b;
            end
            F_DX, F_DY: begin
                dreq.go = !r_run; dreq.num = r_p; dreq.den = $signed({32'd0, r_n});
            end
            F_TA: begin
                mreq.go = !r_run; mreq.a = {32'd0, r_t}; mreq.b = r_a;
            end
            F_V1: begin
                creq.go  = !r_run;
                creq.vec = 1'b1;
                if (r_scaled) begin
                    creq.x = r_a[CW-1:0];
                    creq.y = r_b[CW-1:0];
                end else begin
                    creq.x = 40'(r_a - r_cux);
                    creq.y = 40'(r_b - r_cuy);
                end
            end
            F_V2: begin
                creq.go  = !r_run;
                creq.vec = 1'b1;
                creq.x   = 40'(-r_a - r_cux);
                creq.y   = 40'(-r_b - r_cuy);
            end
            F_CX: begin
                mreq.go = !r_run; mreq.a = r_rx; mreq.b = r_cux;
            end
            F_CY: begin
                mreq.go = !r_run; mreq.a = r_ry; mreq.b = r_cuy;
            end
            F_AMT: begin
                mreq.go = !r_run;
                mreq.a  = 64'(r_rxs) + 64'(r_rys);
                mreq.b  = {48'd0, r_ext[31:16]};
            end
            F_PI: begin
                mreq.go = !r_run; mreq.a = r_amt; mreq.b = PI_Q24;
            end
            F_QR: begin
                dreq.go  = !r_run;
                dreq.num = $signed({32'd0, r_ext});
                dreq.den = $signed(64'(r_steps));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_run   <= 1'b0;
        end else begin
            if (mreq.go || dreq.go || sreq.go || creq.go) begin
                r_run <= 1'b1;
            end else if (unit_done) begin
                r_run <= 1'b0;
            end
            case (r_state)
                F_IDLE: begin
                    if (i_start) begin
                        r_x0  <= i_start_x;
                        r_y0  <= i_start_y;
                        r_xe  <= i_end_x;
                        r_ye  <= i_end_y;
                        r_rx  <= n_rxa;
                        r_ry  <= n_rya;
                        r_phi <= i_rotation;
                        r_la  <= i_large_arc;
                        r_sw  <= i_sweep;
                        r_steps <= STEP_W'(1);
                        if (i_start_x == i_end_x && i_start_y == i_end_y) begin
                            r_state <= F_IDLE;
                        end else if (i_radius_x == 32'sd0 || i_radius_y == 32'sd0) begin
                            r_state <= F_PUSH;
                        end else begin
                            r_state <= F_PHI;
                        end
                    end
                end
                F_PHI: if (cor_done) begin
                    r_c <= cor_x; r_s <= cor_y; r_state <= F_M1;
                end
                F_M1: if (mul_done) begin
                    r_p <= mul_p; r_state <= F_M2;
                end
                F_M2: if (mul_done) begin
                    r_x1 <= rnd_shr(r_p + mul_p, 6'd31); r_state <= F_M3;
                end
                F_M3: if (mul_done) begin
                    r_p <= mul_p; r_state <= F_M4;
                end
                F_M4: if (mul_done) begin
                    r_y1 <= rnd_shr(r_p - mul_p, 6'd31); r_state <= F_DA;
                end
                F_DA: if (div_done) begin
                    r_a  <= div_q;
                    r_ma <= div_q[63] ? 64'(-div_q) : 64'(div_q);
                    r_state <= F_DB;
                end
                F_DB: if (div_done) begin
                    r_b  <= div_q;
                    r_mb <= div_q[63] ? 64'(-div_q) : 64'(div_q);
                    r_sh <= 6'd0;
                    r_state <= F_NORM;
                end
                F_NORM: begin
                    if (r_ma >= RAD_MAX || r_mb >= RAD_MAX) begin
                        r_ma <= r_ma >> 1;
                        r_mb <= r_mb >> 1;
                        r_sh <= r_sh + 6'd1;
                    end else begin
                        r_a <= r_a[63] ? -$signed(r_ma) : $signed(r_ma);
                        r_b <= r_b[63] ? -$signed(r_mb) : $signed(r_mb);
                        r_state <= F_SA;
                    end
                end
                F_SA: if (mul_done) begin
                    r_p <= mul_p; r_state <= F_SB;
                end
                F_SB: if (mul_done) begin
                    r_lsq <= n_lsq;
                    r_state <= (n_lsq == 64'd0) ? F_PUSH : F_SQ;
                end
                F_SQ: if (sqrt_done) begin
                    r_n      <= sqrt_r;
                    r_scaled <= (r_sh != 6'd0) || (r_lsq > ONE_Q60);
                    r_state  <= ((r_sh != 6'd0) || (r_lsq > ONE_Q60)) ? F_RX : F_ST;
                end
                F_RX: if (mul_done) begin
                    r_rxs <= scale_rad(mul_p, r_sh); r_state <= F_RY;
                end
                F_RY: if (mul_done) begin
                    r_rys <= scale_rad(mul_p, r_sh); r_state <= F_V1;
                end
                F_ST: if (sqrt_done) begin
                    r_t <= sqrt_r; r_state <= F_TB;
                end
                F_TB: if (mul_done) begin
                    r_p <= mul_p; r_state <= F_DX;
                end
                F_DX: if (div_done) begin
                    r_cux <= div_q; r_state <= F_TA;
                end
                F_TA: if (mul_done) begin
                    r_p <= mul_p; r_state <= F_DY;
                end
                F_DY: if (div_done) begin
                    if (r_la == r_sw) begin
                        r_cux <= -r_cux;
                        r_cuy <= div_q;
                    end else begin
                        r_cuy <= -div_q;
                    end
                    r_state <= F_V1;
                end
                F_V1: if (cor_done) begin
                    r_th1 <= cor_z;
                    if (r_scaled) begin
                        r_ext   <= HALF_TURN;
                        r_cx1   <= '0;
                        r_cy1   <= '0;
                        r_state <= F_AMT;
                    end else begin
                        r_state <= F_V2;
                    end
                end
                F_V2: if (cor_done) begin
                    r_ext   <= r_sw ? n_d : -n_d;
                    r_rxs   <= r_rx[31:0];
                    r_rys   <= r_ry[31:0];
                    r_state <= F_CX;
                end
                F_CX: if (mul_done) begin
                    r_cx1 <= 34'(rnd_shr(mul_p, 6'd30)); r_state <= F_CY;
                end
                F_CY: if (mul_done) begin
                    r_cy1 <= 34'(rnd_shr(mul_p, 6'd30)); r_state <= F_AMT;
                end
                F_AMT: if (mul_done) begin
                    r_amt <= mul_p;
                    if (mul_p >= AMT_SAT) begin
                        r_steps <= STEP_W'(MAX_SEGMENTS);
                        r_state <= F_QR;
                    end else begin
                        r_state <= F_PI;
                    end
                end
                F_PI: if (mul_done) begin
                    if (n_prod > n_maxs) begin
                        r_steps <= STEP_W'(MAX_SEGMENTS);
                    end else if (n_prod == 64'd0) begin
                        r_steps <= STEP_W'(1);
                    end else begin
                        r_steps <= n_prod[STEP_W-1:0];
                    end
                    r_state <= F_QR;
                end
                F_QR: if (div_done) begin
                    r_qstep <= div_q[31:0];
                    r_rstep <= div_r[STEP_W-1:0];
                    r_state <= F_PUSH;
                end
                F_PUSH: if (!i_full) begin
                    r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_comb begin
        o_job.xe    = r_xe;
        o_job.ye    = r_ye;
        o_job.sumx  = 33'(r_x0) + 33'(r_xe);
        o_job.sumy  = 33'(r_y0) + 33'(r_ye);
        o_job.c     = r_c;
        o_job.s     = r_s;
        o_job.cx1   = r_cx1;
        o_job.cy1   = r_cy1;
        o_job.rxs   = r_rxs;
        o_job.rys   = r_rys;
        o_job.th1   = r_th1;
        o_job.sw    = r_sw;
        o_job.qstep = r_qstep;
        o_job.rstep = r_rstep;
        o_job.steps = r_steps;
    end

    assign o_push = (r_state == F_PUSH) && !i_full;
    assign o_busy = (r_state != F_IDLE);
endmodule

@@ design/eaf_queue.sv @@
// Two-entry register queue of setup records between the front and back parts.
// Uses the record type of eaf_pkg.
module eaf_queue import eaf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_job;
                r_wp        <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("queue pop while empty");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd3) && ((r_cnt == 2'd0) == (r_wp == r_rp) || r_cnt == 2'd2))
        else $error("queue count and pointers disagree");
endmodule

@@ design/eaf_back.sv @@
// Point generator: steps along each queued arc and emits the chord endpoints.
// Uses eaf_pkg and the eaf_mul and eaf_cordic units.
module eaf_back import eaf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  t_job               i_job,
    output logic               o_pop,
    output logic               o_valid,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic               o_last
);
    localparam logic [3:0] B_IDLE = 4'd0, B_NEXT = 4'd1, B_COS = 4'd2, B_M1 = 4'd3;
    localparam logic [3:0] B_M2 = 4'd4,   B_M3 = 4'd5,   B_M4 = 4'd6,  B_M5 = 4'd7;
    localparam logic [3:0] B_M6 = 4'd8,   B_OUT = 4'd9,  B_LAST = 4'd10;

    logic [3:0]           r_state;
    logic                 r_run;
    t_job                 r_job;
    logic [31:0]          r_q, r_ang;
    logic [STEP_W-1:0]    r_r, r_k;
    logic signed [CW-1:0] r_co, r_si;
    logic signed [63:0]   r_sx, r_sy, r_p, r_ox, r_oy;
    logic                 r_valid, r_last;
    logic signed [31:0]   r_px, r_py;

    t_mul_req mreq;
    t_cor_req creq;
    logic                 mul_done, cor_done;
    logic [63:0]          mul_p;
    logic signed [CW-1:0] cor_x, cor_y;
    logic [31:0]          cor_z;
    logic [STEP_W:0]      n_r;
    logic [31:0]          n_q;

    eaf_mul    u_mul (.i_clk, .i_rst_n, .i_req(mreq), .o_done(mul_done), .o_p(mul_p));
    eaf_cordic u_cor (.i_clk, .i_rst_n, .i_req(creq), .o_done(cor_done),
                      .o_x(cor_x), .o_y(cor_y), .o_z(cor_z));

    always_comb begin
        n_r = {1'b0, r_r} + {1'b0, r_job.rstep};
        n_q = r_q + r_job.qstep;
        if (n_r >= {1'b0, r_job.steps}) begin
            n_r = n_r - {1'b0, r_job.steps};
            n_q = n_q + 32'd1;
        end
    end

    always_comb begin
        mreq = '0;
        creq = '0;
        case (r_state)
            B_COS: begin
                creq.go = !r_run; creq.ang = r_ang;
            end
            B_M1: begin
                mreq.go = !r_run; mreq.a = {32'd0, r_job.rxs}; mreq.b = sx64(r_co);
            end
            B_M2: begin
                mreq.go = !r_run; mreq.a = {32'd0, r_job.rys}; mreq.b = sx64(r_si);
            end
            B_M3: begin
                mreq.go = !r_run; mreq.a = sx64(r_job.c); mreq.b = r_sx;
            end
            B_M4: begin
                mreq.go = !r_run; mreq.a = sx64(r_job.s); mreq.b = r_sy;
            end
            B_M5: begin
                mreq.go = !r_run; mreq.a = sx64(r_job.s); mreq.b = r_sx;
            end
            B_M6: begin
                mreq.go = !r_run; mreq.a = sx64(r_job.c); mreq.b = r_sy;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_run   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (mreq.go || creq.go) begin
                r_run <= 1'b1;
            end else if (mul_done || cor_done) begin
                r_run <= 1'b0;
            end
            case (r_state)
                B_IDLE: if (!i_empty) begin
                    r_job   <= i_job;
                    r_q     <= 32'd0;
                    r_r     <= '0;
                    r_k     <= STEP_W'(1);
                    r_state <= B_NEXT;
                end
                B_NEXT: begin
                    if (r_k < r_job.steps) begin
                        r_q     <= n_q;
                        r_r     <= n_r[STEP_W-1:0];
                        r_ang   <= r_job.sw ? r_job.th1 + n_q : r_job.th1 - n_q;
                        r_state <= B_COS;
                    end else begin
                        r_state <= B_LAST;
                    end
                end
                B_COS: if (cor_done) begin
                    r_co <= cor_x; r_si <= cor_y; r_state <= B_M1;
                end
                B_M1: if (mul_done) begin
                    r_sx <= 64'(r_job.cx1) + rnd_shr(mul_p, 6'd30); r_state <= B_M2;
                end
                B_M2: if (mul_done) begin
                    r_sy <= 64'(r_job.cy1) + rnd_shr(mul_p, 6'd30); r_state <= B_M3;
                end
                B_M3: if (mul_done) begin
                    r_p <= mul_p; r_state <= B_M4;
                end
                B_M4: if (mul_done) begin
                    r_ox <= rnd_shr(r_p - mul_p, 6'd30); r_state <= B_M5;
                end
                B_M5: if (mul_done) begin
                    r_p <= mul_p; r_state <= B_M6;
                end
                B_M6: if (mul_done) begin
                    r_oy <= rnd_shr(r_p + mul_p, 6'd30); r_state <= B_OUT;
                end
                B_OUT: begin
                    r_valid <= 1'b1;
                    r_last  <= 1'b0;
                    r_px    <= sat32(rnd_shr(64'(r_job.sumx) + (r_ox <<< 1), 6'd1));
                    r_py    <= sat32(rnd_shr(64'(r_job.sumy) + (r_oy <<< 1), 6'd1));
                    r_k     <= r_k + STEP_W'(1);
                    r_state <= B_NEXT;
                end
                B_LAST: begin
                    r_valid <= 1'b1;
                    r_last  <= 1'b1;
                    r_px    <= r_job.xe;
                    r_py    <= r_job.ye;
                    r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_pop     = (r_state == B_IDLE) && !i_empty;
    assign o_valid   = r_valid;
    assign o_point_x = r_px;
    assign o_point_y = r_py;
    assign o_last    = r_last;
endmodule

@@ design/elliptical_arc_flattener.sv @@
// Top level of the elliptical arc flattener: setup front, record queue, point back.
// Depends on eaf_pkg, eaf_front, eaf_queue and eaf_back.
//
//   channel   direction   handshake                 payload
//   arc in    input       start high, busy low      i_start_x .. i_end_y
//   point     output      o_valid strobe, 1 cycle   o_point_x, o_point_y, o_last
//
// Setup of one arc runs through the divides, square roots, multiplies and CORDIC steps
// of the front; a zero radius skips them and goes straight to the push.
// Each point then takes one CORDIC rotation and six multiplies in the back.
// The front takes the next arc while the back emits points, up to two queued records.
// Reset is synchronous and active low; it clears all control state.
// The receiver cannot stall: every result appears for exactly one cycle.
module elliptical_arc_flattener import eaf_pkg::*; #(
    parameter int MAX_SEGMENTS = MAX_SEG_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [31:0] i_radius_x,
    input  logic signed [31:0] i_radius_y,
    input  logic [15:0]        i_rotation,
    input  logic               i_large_arc,
    input  logic               i_sweep,
    input  logic signed [31:0] i_end_x,
    input  logic signed [31:0] i_end_y,
    output logic               o_valid,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic               o_last
);
    t_job push_job, pop_job;
    logic push, full, pop, empty;

    eaf_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
        .i_clk, .i_rst_n,
        .i_start(start), .o_busy(busy),
        .i_start_x, .i_start_y, .i_radius_x, .i_radius_y,
        .i_rotation, .i_large_arc, .i_sweep, .i_end_x, .i_end_y,
        .i_full(full), .o_push(push), .o_job(push_job)
    );

    eaf_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push(push), .i_job(push_job), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_job(pop_job)
    );

    eaf_back u_back (
        .i_clk, .i_rst_n,
        .i_empty(empty), .i_job(pop_job), .o_pop(pop),
        .o_valid, .o_point_x, .o_point_y, .o_last
    );
endmodule
